[rtl/pqpg_pkg.sv]
package pqpg_pkg;

  localparam int POS_FRAC_BITS  = 8;
  localparam int UNIT_FRAC_BITS = 14;
  localparam int TC_FRAC_BITS   = 8;
  localparam int UNIT_ONE       = 1 << UNIT_FRAC_BITS;
  localparam longint RND_HALF   = 64'sd1 <<< (UNIT_FRAC_BITS - 1);

  // boundary arithmetic
  localparam int BND_ONE_SQ   = 1 << (2 * POS_FRAC_BITS);
  localparam int BND_SMALL_SH = TC_FRAC_BITS + POS_FRAC_BITS + 1;

  // pipelined iterative units
  localparam int SQRT_STEPS = 31;
  localparam int DIV_Q_BITS = UNIT_FRAC_BITS + 1;
  localparam int U2_LAT     = 6 + SQRT_STEPS + 1 + DIV_Q_BITS + 1;

  // config register reset values
  localparam logic [15:0] RST_LAT_TC      = 16'd1280;
  localparam logic [15:0] RST_VERT_TC     = 16'd1280;
  localparam logic        RST_FIX_ON      = 1'b1;
  localparam logic [22:0] RST_FIX_BOUND   = 23'd1280;
  localparam logic [14:0] RST_MAX_CLIMB   = 15'd4842;

  typedef enum logic [2:0] {
    REG_LAT_TC    = 3'd0,
    REG_VERT_TC   = 3'd1,
    REG_FIX_ON    = 3'd2,
    REG_FIX_BOUND = 3'd3,
    REG_MAX_CLIMB = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic ez;
    logic bz;
    logic ge;
  } uerr_flags_t;

  // round to nearest, ties away from zero, by 2^UNIT_FRAC_BITS
  function automatic logic signed [63:0] rsh_unit(input logic signed [63:0] x);
    logic signed [63:0] h;
    h = x[63] ? (RND_HALF - 64'sd1) : RND_HALF;
    return (x + h) >>> UNIT_FRAC_BITS;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return 32'(x);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [63:0] x);
    if (x > 64'sd32767) return 16'sh7fff;
    if (x < -64'sd32768) return 16'sh8000;
    return 16'(x);
  endfunction

endpackage

[rtl/pqpg_delay.sv]
module pqpg_delay #(
  parameter int W = 1,
  parameter int L = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] sr [0:L-1];

  always_ff @(posedge clk) begin
    if (en) begin
      sr[0] <= din;
      for (int k = 1; k < L; k++) sr[k] <= sr[k-1];
    end
  end

  assign dout = sr[L-1];

endmodule

[rtl/pqpg_isqrt.sv]
module pqpg_isqrt #(
  parameter int XW = 61,
  parameter int RW = 31
) (
  input  logic          clk,
  input  logic          en,
  input  logic [XW-1:0] x,
  output logic [RW-1:0] root
);

  localparam int IW = 2 * RW;

  logic [IW-1:0] xs [0:RW-1];
  logic [IW-1:0] rs [0:RW-1];
  logic [IW-1:0] nx [0:RW-1];
  logic [IW-1:0] nr [0:RW-1];

  // one result bit per stage
  always_comb begin
    logic [IW-1:0] xi, ri, bitv, trial;
    for (int k = 0; k < RW; k++) begin
      xi    = (k == 0) ? IW'(x) : xs[(k == 0) ? 0 : k-1];
      ri    = (k == 0) ? '0 : rs[(k == 0) ? 0 : k-1];
      bitv  = IW'(1) << (2 * (RW - 1 - k));
      trial = ri + bitv;
      if (xi >= trial) begin
        nx[k] = xi - trial;
        nr[k] = (ri >> 1) + bitv;
      end else begin
        nx[k] = xi;
        nr[k] = ri >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < RW; k++) begin
        xs[k] <= nx[k];
        rs[k] <= nr[k];
      end
    end
  end

  assign root = RW'(rs[RW-1]);

endmodule

[rtl/pqpg_div.sv]
module pqpg_div #(
  parameter int NW = 40,
  parameter int DW = 24,
  parameter int QW = 15
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] n,
  input  logic [DW-1:0] d,
  output logic [QW-1:0] q
);

  localparam int WW = DW + QW;

  logic [WW-1:0] rem [0:QW-1];
  logic [DW-1:0] dv  [0:QW-1];
  logic [QW-1:0] qv  [0:QW-1];
  logic [WW-1:0] nrem [0:QW-1];
  logic [QW-1:0] nq   [0:QW-1];
  logic [DW-1:0] nd   [0:QW-1];

  // restoring division, one quotient bit per stage, msb first
  always_comb begin
    logic [WW-1:0] ri, sh;
    logic [DW-1:0] di;
    logic [QW-1:0] qi;
    for (int k = 0; k < QW; k++) begin
      ri = (k == 0) ? WW'(n) : rem[(k == 0) ? 0 : k-1];
      di = (k == 0) ? d : dv[(k == 0) ? 0 : k-1];
      qi = (k == 0) ? '0 : qv[(k == 0) ? 0 : k-1];
      sh = WW'(di) << (QW - 1 - k);
      nd[k] = di;
      if (ri >= sh) begin
        nrem[k] = ri - sh;
        nq[k]   = qi | (QW'(1) << (QW - 1 - k));
      end else begin
        nrem[k] = ri;
        nq[k]   = qi;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QW; k++) begin
        rem[k] <= nrem[k];
        dv[k]  <= nd[k];
        qv[k]  <= nq[k];
      end
    end
  end

  assign q = qv[QW-1];

endmodule

[rtl/pqpg_unit2.sv]
module pqpg_unit2 import pqpg_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [15:0] ua,
  output logic signed [15:0] ub
);

  logic [32:0] ma1, mb1, ma2, mb2, m2, ma3, mb3;
  logic        sa1, sb1, sa2, sb2, sa3, sb3, zero3;
  logic [5:0]  p3, msb;
  logic [29:0] na4, nb4, na_d, nb_d;
  logic [59:0] sqa5, sqb5;
  logic [60:0] sum6;
  logic [SQRT_STEPS-1:0] len;
  logic [44:0] numa, numb;
  logic [SQRT_STEPS-1:0] len38;
  logic [DIV_Q_BITS-1:0] qa, qb;
  logic [2:0]  fl_d;
  logic [5:0]  rsh_amt, lsh_amt;

  always_comb begin
    msb = '0;
    for (int i = 0; i < 33; i++) if (m2[i]) msb = 6'(i);
  end

  assign rsh_amt = p3 - 6'd29;
  assign lsh_amt = 6'd29 - p3;

  always_ff @(posedge clk) begin
    if (en) begin
      ma1 <= a[32] ? 33'(-a) : 33'(a);
      mb1 <= b[32] ? 33'(-b) : 33'(b);
      sa1 <= a[32];
      sb1 <= b[32];
      ma2 <= ma1;
      mb2 <= mb1;
      m2  <= (ma1 > mb1) ? ma1 : mb1;
      sa2 <= sa1;
      sb2 <= sb1;
      ma3   <= ma2;
      mb3   <= mb2;
      p3    <= msb;
      zero3 <= (m2 == '0);
      sa3   <= sa2;
      sb3   <= sb2;
      // larger magnitude lands in [2^29, 2^30)
      if (p3 >= 6'd29) begin
        na4 <= 30'(ma3 >> rsh_amt);
        nb4 <= 30'(mb3 >> rsh_amt);
      end else begin
        na4 <= 30'(ma3 << lsh_amt);
        nb4 <= 30'(mb3 << lsh_amt);
      end
      sqa5 <= na4 * na4;
      sqb5 <= nb4 * nb4;
      sum6 <= 61'(sqa5) + 61'(sqb5);
      numa  <= 45'({na_d, {UNIT_FRAC_BITS{1'b0}}}) + 45'(len >> 1);
      numb  <= 45'({nb_d, {UNIT_FRAC_BITS{1'b0}}}) + 45'(len >> 1);
      len38 <= len;
      // sign and zero restored after the divide
      if (fl_d[0]) begin
        ua <= '0;
        ub <= '0;
      end else begin
        ua <= fl_d[2] ? -16'(qa) : 16'(qa);
        ub <= fl_d[1] ? -16'(qb) : 16'(qb);
      end
    end
  end

  pqpg_isqrt #(.XW(61), .RW(SQRT_STEPS)) u_sqrt (
    .clk(clk), .en(en), .x(sum6), .root(len)
  );

  pqpg_delay #(.W(60), .L(2 + SQRT_STEPS)) u_dly_norm (
    .clk(clk), .en(en), .din({na4, nb4}), .dout({na_d, nb_d})
  );

  pqpg_delay #(.W(3), .L(U2_LAT - 4)) u_dly_flags (
    .clk(clk), .en(en), .din({sa3, sb3, zero3}), .dout(fl_d)
  );

  pqpg_div #(.NW(45), .DW(SQRT_STEPS), .QW(DIV_Q_BITS)) u_div_a (
    .clk(clk), .en(en), .n(numa), .d(len38), .q(qa)
  );

  pqpg_div #(.NW(45), .DW(SQRT_STEPS), .QW(DIV_Q_BITS)) u_div_b (
    .clk(clk), .en(en), .n(numb), .d(len38), .q(qb)
  );

endmodule

[rtl/piecewise_quadratic_path_guidance.sv]
// throughput: one item per cycle; the whole pipeline advances together and
// freezes only while a result sits on the output and is stalled
// the two unit-vector units (sqrt and divide, one bit per stage) set the depth
// reset clears all valid bits and returns the config registers to their defaults
module piecewise_quadratic_path_guidance import pqpg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] path_north,
  input  logic signed [31:0] path_east,
  input  logic signed [31:0] path_down,
  input  logic signed [15:0] tangent_north,
  input  logic signed [15:0] tangent_east,
  input  logic signed [15:0] tangent_down,
  input  logic signed [31:0] vehicle_north,
  input  logic signed [31:0] vehicle_east,
  input  logic signed [31:0] vehicle_down,
  input  logic signed [16:0] velocity_down,
  input  logic        [15:0] horizontal_speed,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] setpoint_north,
  output logic signed [15:0] setpoint_east,
  output logic signed [15:0] setpoint_down,
  output logic signed [31:0] lateral_error,
  output logic signed [31:0] vertical_error,
  output logic        [14:0] lateral_error_unit,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic        [2:0]  cfg_index,
  input  logic        [22:0] cfg_data
);

  localparam int ST_U2_OUT = 2 + U2_LAT;
  localparam int ST_ELAT   = ST_U2_OUT + 3;
  localparam int ST_UERR   = ST_ELAT + 1;
  localparam int ST_Q      = ST_UERR + DIV_Q_BITS;
  localparam int ST_UNIT   = ST_Q + 1;
  localparam int ST_THETA  = ST_Q + 3;
  localparam int ST_Z      = ST_THETA + 3;
  localparam int ST_ZS     = ST_THETA + 5;
  localparam int ST_OUT    = ST_ZS + 2;

  // config registers
  logic [15:0] lat_tc, vert_tc;
  logic        fix_on;
  logic [22:0] fix_bound;
  logic [14:0] max_climb;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lat_tc    <= RST_LAT_TC;
      vert_tc   <= RST_VERT_TC;
      fix_on    <= RST_FIX_ON;
      fix_bound <= RST_FIX_BOUND;
      max_climb <= RST_MAX_CLIMB;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LAT_TC:    lat_tc    <= cfg_data[15:0];
        REG_VERT_TC:   vert_tc   <= cfg_data[15:0];
        REG_FIX_ON:    fix_on    <= cfg_data[0];
        REG_FIX_BOUND: fix_bound <= cfg_data;
        REG_MAX_CLIMB: max_climb <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic              adv;
  logic [ST_OUT-1:0] vld;

  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;
  assign out_valid = vld[ST_OUT-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[ST_OUT-2:0], in_valid};
  end

  // stage 1: input capture
  logic signed [31:0] pn1, pe1, pd1, vn1, ve1, vd1;
  logic signed [15:0] tn1, te1, td1;
  logic signed [16:0] vel1;
  logic        [15:0] vh1;

  always_ff @(posedge clk) begin
    if (adv) begin
      pn1 <= path_north;
      pe1 <= path_east;
      pd1 <= path_down;
      tn1 <= tangent_north;
      te1 <= tangent_east;
      td1 <= tangent_down;
      vn1 <= vehicle_north;
      ve1 <= vehicle_east;
      vd1 <= vehicle_down;
      vel1 <= velocity_down;
      vh1  <= horizontal_speed;
    end
  end

  // stage 2: offsets, vertical error, boundary prep
  logic signed [32:0] dn2, de2, tn2, te2;
  logic signed [31:0] elon2;
  logic signed [15:0] td2;
  logic [16:0] bvl2, bvv2, vmag;
  logic        sml2, smv2;
  logic [2*POS_FRAC_BITS-1:0] sql2, sqv2;

  assign vmag = vel1[16] ? 17'(-vel1) : 17'(vel1);

  always_ff @(posedge clk) begin
    if (adv) begin
      dn2   <= vn1 - pn1;
      de2   <= ve1 - pe1;
      elon2 <= sat32(64'(pd1) - 64'(vd1));
      tn2   <= tn1;
      te2   <= te1;
      td2   <= td1;
      bvl2  <= {1'b0, vh1};
      sml2  <= {1'b0, vh1} < (17'(1) << POS_FRAC_BITS);
      sql2  <= vh1[POS_FRAC_BITS-1:0] * vh1[POS_FRAC_BITS-1:0];
      bvv2  <= vmag;
      smv2  <= vmag < (17'(1) << POS_FRAC_BITS);
      sqv2  <= vmag[POS_FRAC_BITS-1:0] * vmag[POS_FRAC_BITS-1:0];
    end
  end

  // stages 3-4: error boundaries, quadratic below 1 m/s
  logic [16:0] opl, opv;
  logic [32:0] prl3, prv3;
  logic        sml3, smv3;
  logic [23:0] bl4, bv4, bvs;

  assign opl = sml2 ? 17'(BND_ONE_SQ) + 17'(sql2) : bvl2;
  assign opv = smv2 ? 17'(BND_ONE_SQ) + 17'(sqv2) : bvv2;
  assign bvs = smv3 ? 24'((34'(prv3) + (34'(1) << (BND_SMALL_SH - 1))) >> BND_SMALL_SH)
                    : 24'((34'(prv3) + (34'(1) << (TC_FRAC_BITS - 1))) >> TC_FRAC_BITS);

  always_ff @(posedge clk) begin
    if (adv) begin
      prl3 <= lat_tc * opl;
      prv3 <= vert_tc * opv;
      sml3 <= sml2;
      smv3 <= smv2;
      bl4  <= sml3 ? 24'((34'(prl3) + (34'(1) << (BND_SMALL_SH - 1))) >> BND_SMALL_SH)
                   : 24'((34'(prl3) + (34'(1) << (TC_FRAC_BITS - 1))) >> TC_FRAC_BITS);
      bv4  <= fix_on ? 24'(fix_bound) : bvs;
    end
  end

  // unit tangent and unit offset
  logic signed [15:0] utn, ute, en_u, ee_u;

  pqpg_unit2 u_tan (.clk(clk), .en(adv), .a(tn2), .b(te2), .ua(utn), .ub(ute));
  pqpg_unit2 u_off (.clk(clk), .en(adv), .a(dn2), .b(de2), .ua(en_u), .ub(ee_u));

  logic signed [32:0] dn56, de56;

  pqpg_delay #(.W(66), .L(ST_U2_OUT - 2)) u_dly_off (
    .clk(clk), .en(adv), .din({dn2, de2}), .dout({dn56, de56})
  );

  // lateral error: offset crossed with unit tangent
  logic signed [48:0] cp1, cp2;
  logic signed [49:0] cdiff;
  logic signed [31:0] elat59, elon59;
  logic [23:0] bl59, bv59;

  always_ff @(posedge clk) begin
    if (adv) begin
      cp1    <= dn56 * ute;
      cp2    <= de56 * utn;
      cdiff  <= cp1 - cp2;
      elat59 <= sat32(rsh_unit(cdiff));
    end
  end

  pqpg_delay #(.W(32), .L(ST_ELAT - 2)) u_dly_elon (
    .clk(clk), .en(adv), .din(elon2), .dout(elon59)
  );

  pqpg_delay #(.W(48), .L(ST_ELAT - 4)) u_dly_bnd (
    .clk(clk), .en(adv), .din({bl4, bv4}), .dout({bl59, bv59})
  );

  // normalized errors
  logic [31:0] eml, emv;
  logic [39:0] numl, numv;
  logic [23:0] bl60, bv60;
  uerr_flags_t fll60, flv60, fll_d, flv_d;
  logic [DIV_Q_BITS-1:0] ql, qv;

  assign eml = elat59[31] ? 32'(-elat59) : 32'(elat59);
  assign emv = elon59[31] ? 32'(-elon59) : 32'(elon59);

  always_ff @(posedge clk) begin
    if (adv) begin
      numl     <= 40'({eml, {UNIT_FRAC_BITS{1'b0}}}) + 40'(bl59 >> 1);
      numv     <= 40'({emv, {UNIT_FRAC_BITS{1'b0}}}) + 40'(bv59 >> 1);
      bl60     <= bl59;
      bv60     <= bv59;
      fll60.ez <= (eml == '0);
      fll60.bz <= (bl59 == '0);
      fll60.ge <= (eml >= {8'b0, bl59});
      flv60.ez <= (emv == '0);
      flv60.bz <= (bv59 == '0);
      flv60.ge <= (emv >= {8'b0, bv59});
    end
  end

  pqpg_div #(.NW(40), .DW(24), .QW(DIV_Q_BITS)) u_div_lat (
    .clk(clk), .en(adv), .n(numl), .d(bl60), .q(ql)
  );

  pqpg_div #(.NW(40), .DW(24), .QW(DIV_Q_BITS)) u_div_ver (
    .clk(clk), .en(adv), .n(numv), .d(bv60), .q(qv)
  );

  pqpg_delay #(.W(6), .L(ST_Q - ST_UERR)) u_dly_uflg (
    .clk(clk), .en(adv), .din({fll60, flv60}), .dout({fll_d, flv_d})
  );

  // blend theta = 2u - u^2
  logic [14:0] ul76, uv76, ul77, uv77, thl78, thv78;
  logic [29:0] usql, usqv;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (fll_d.bz)      ul76 <= fll_d.ez ? '0 : 15'(UNIT_ONE);
      else if (fll_d.ge) ul76 <= 15'(UNIT_ONE);
      else               ul76 <= ql;
      if (flv_d.bz)      uv76 <= flv_d.ez ? '0 : 15'(UNIT_ONE);
      else if (flv_d.ge) uv76 <= 15'(UNIT_ONE);
      else               uv76 <= qv;
      usql <= ul76 * ul76;
      usqv <= uv76 * uv76;
      ul77 <= ul76;
      uv77 <= uv76;
      thl78 <= 15'((64'(ul77) << 1) - rsh_unit(64'(usql)));
      thv78 <= 15'((64'(uv77) << 1) - rsh_unit(64'(usqv)));
    end
  end

  // side data to the blend stage
  logic signed [15:0] td78, utn78, ute78, en78, ee78;
  logic               eneg78, elnz78;

  pqpg_delay #(.W(16), .L(ST_THETA - 2)) u_dly_td (
    .clk(clk), .en(adv), .din(td2), .dout(td78)
  );

  pqpg_delay #(.W(64), .L(ST_THETA - ST_U2_OUT)) u_dly_units (
    .clk(clk), .en(adv), .din({utn, ute, en_u, ee_u}), .dout({utn78, ute78, en78, ee78})
  );

  pqpg_delay #(.W(2), .L(ST_THETA - ST_ELAT)) u_dly_sgn (
    .clk(clk), .en(adv), .din({elon59[31], (elat59 != '0)}), .dout({eneg78, elnz78})
  );

  // down setpoint
  logic signed [16:0] thcv, thcl, thls;
  logic signed [32:0] za;
  logic        [29:0] zb;
  logic signed [31:0] zbs;
  logic               zneg;
  logic signed [33:0] zsum;
  logic signed [15:0] z81, z84;
  logic signed [31:0] zz;
  logic signed [17:0] zs83;

  assign thcv = $signed(17'(UNIT_ONE) - {2'b0, thv78});
  assign thcl = $signed(17'(UNIT_ONE) - {2'b0, thl78});
  assign thls = $signed({2'b0, thl78});
  assign zbs  = $signed({2'b0, zb});

  always_ff @(posedge clk) begin
    if (adv) begin
      za   <= thcv * td78;
      zb   <= thv78 * max_climb;
      zneg <= eneg78;
      zsum <= za + (zneg ? -zbs : zbs);
      z81  <= sat16(rsh_unit(zsum));
      zz   <= z81 * z81;
      zs83 <= 18'(64'(UNIT_ONE) - rsh_unit(zz));
    end
  end

  // horizontal setpoint
  logic signed [15:0] eng_n, eng_e;
  logic signed [32:0] xan, xbn, xae, xbe;
  logic signed [33:0] xdn, xde;
  logic signed [17:0] xn81, xe81, xn83, xe83;
  logic signed [35:0] xpn, xpe;

  // a zero lateral error drops the offset direction
  assign eng_n = elnz78 ? en78 : '0;
  assign eng_e = elnz78 ? ee78 : '0;

  always_ff @(posedge clk) begin
    if (adv) begin
      xan  <= thcl * utn78;
      xbn  <= thls * eng_n;
      xae  <= thcl * ute78;
      xbe  <= thls * eng_e;
      xdn  <= xan - xbn;
      xde  <= xae - xbe;
      xn81 <= 18'(rsh_unit(xdn));
      xe81 <= 18'(rsh_unit(xde));
      xpn  <= xn83 * zs83;
      xpe  <= xe83 * zs83;
    end
  end

  pqpg_delay #(.W(36), .L(ST_ZS - ST_Z)) u_dly_xy (
    .clk(clk), .en(adv), .din({xn81, xe81}), .dout({xn83, xe83})
  );

  // output alignment
  logic signed [31:0] elat84, elon84;
  logic        [14:0] ul84;

  pqpg_delay #(.W(16), .L(ST_OUT - 1 - ST_Z)) u_dly_z (
    .clk(clk), .en(adv), .din(z81), .dout(z84)
  );

  pqpg_delay #(.W(64), .L(ST_OUT - 1 - ST_ELAT)) u_dly_err (
    .clk(clk), .en(adv), .din({elat59, elon59}), .dout({elat84, elon84})
  );

  pqpg_delay #(.W(15), .L(ST_OUT - 1 - ST_UNIT)) u_dly_ul (
    .clk(clk), .en(adv), .din(ul76), .dout(ul84)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      setpoint_north     <= sat16(rsh_unit(xpn));
      setpoint_east      <= sat16(rsh_unit(xpe));
      setpoint_down      <= z84;
      lateral_error      <= elat84;
      vertical_error     <= elon84;
      lateral_error_unit <= ul84;
    end
  end

endmodule
